FILE: design/core_hotplug_load_governor_assert.svh
// assertion macros shared by the governor rtl
`ifndef CORE_HOTPLUG_LOAD_GOVERNOR_ASSERT_SVH
`define CORE_HOTPLUG_LOAD_GOVERNOR_ASSERT_SVH

`ifndef SYNTH

// antecedent implies consequent in the same cycle
`define CHLG_ASSERT_IMP(lbl, ant, con) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (con)) \
    else $error("assertion failed: implication");

// antecedent implies consequent in the next cycle
`define CHLG_ASSERT_NXT(lbl, ant, con) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (con)) \
    else $error("assertion failed: next-cycle implication");

`else

`define CHLG_ASSERT_IMP(lbl, ant, con)
`define CHLG_ASSERT_NXT(lbl, ant, con)

`endif

`endif

FILE: design/chlg_pkg.sv
package chlg_pkg;

  localparam int NUM_CORES_DEF = 4;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 48;

  // register indexes of the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ALL_ON_THRESHOLD = 3'd0,
    REG_UP_THRESHOLDS    = 3'd1,
    REG_DOWN_THRESHOLDS  = 3'd2,
    REG_INTERVAL_TABLE   = 3'd3,
    REG_DOWN_PERIODS     = 3'd4,
    REG_UP_PERIOD        = 3'd5,
    REG_LOAD_SCALE       = 3'd6,
    REG_MIN_CORES        = 3'd7
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ACT_NONE        = 2'd0,
    ACT_ONLINE_ONE  = 2'd1,
    ACT_ONLINE_ALL  = 2'd2,
    ACT_OFFLINE_ONE = 2'd3
  } action_t;

  // reset values of the registers
  localparam logic [15:0] RST_ALL_ON_THRESHOLD = 16'd800;
  localparam logic [47:0] RST_UP_THRESHOLDS    = 48'h0001_400D_C064; // 100 220 320 0
  localparam logic [47:0] RST_DOWN_THRESHOLDS  = 48'h0F00_A001_E000; // 0 30 160 240
  localparam logic [31:0] RST_INTERVAL_TABLE   = 32'h3264_9632;      // 50 150 100 50
  localparam logic [15:0] RST_DOWN_PERIODS     = 16'h45A0;           // 0 10 5 4
  localparam logic [3:0]  RST_UP_PERIOD        = 4'd3;
  localparam logic [1:0]  RST_LOAD_SCALE       = 2'd1;
  localparam logic [2:0]  RST_MIN_CORES        = 3'd1;
  localparam logic [3:0]  RST_STREAK           = 4'd1;

  typedef struct packed {
    logic [15:0] all_on_threshold;
    logic [47:0] up_thresholds;
    logic [47:0] down_thresholds;
    logic [31:0] interval_table;
    logic [15:0] down_periods;
    logic [3:0]  up_period;
    logic [1:0]  load_scale;
    logic [2:0]  min_cores;
  } cfg_regs_t;

  typedef struct packed {
    logic [3:0] up_streak;
    logic [3:0] down_streak;
  } streak_t;

  typedef struct packed {
    logic [15:0] load_avg;
    logic [2:0]  cores_online;
  } in_item_t;

  typedef struct packed {
    action_t     action;
    logic [1:0]  target_core;
    logic [2:0]  new_cores_online;
    logic [9:0]  next_interval_ms;
  } out_item_t;

endpackage

FILE: design/chlg_decide.sv
module chlg_decide #(
  parameter int NUM_CORES = chlg_pkg::NUM_CORES_DEF
) (
  input  chlg_pkg::cfg_regs_t cfg,
  input  chlg_pkg::in_item_t  item,
  input  chlg_pkg::streak_t   streak,
  output chlg_pkg::out_item_t result,
  output chlg_pkg::streak_t   streak_nxt
);
  import chlg_pkg::*;

  localparam logic [2:0] NCORES = 3'(NUM_CORES);

  logic [2:0]  c_sat;
  logic [1:0]  c_idx;
  logic [2:0]  floor_cores;
  logic [11:0] dn_th;
  logic [11:0] up_th;
  logic [13:0] up_th_scaled;
  logic [3:0]  dn_period;
  logic [2:0]  next_c;
  logic [1:0]  next_idx;
  logic [7:0]  base_ivl;

  always_comb begin
    // clamp the online count into 1..NUM_CORES
    if (item.cores_online == 3'd0) begin
      c_sat = 3'd1;
    end else if (item.cores_online > NCORES) begin
      c_sat = NCORES;
    end else begin
      c_sat = item.cores_online;
    end
    c_idx       = 2'(c_sat - 3'd1);
    floor_cores = (cfg.min_cores == 3'd0) ? 3'd1 : cfg.min_cores;

    dn_th        = cfg.down_thresholds[c_idx*12 +: 12];
    up_th        = cfg.up_thresholds[c_idx*12 +: 12];
    up_th_scaled = 14'(up_th) * 14'(cfg.load_scale);
    dn_period    = cfg.down_periods[c_idx*4 +: 4];

    result.action      = ACT_NONE;
    result.target_core = 2'd0;
    next_c             = c_sat;
    streak_nxt         = streak;

    if ((item.load_avg <= 16'(dn_th)) && (c_sat > floor_cores)) begin
      if (streak.down_streak >= dn_period) begin
        result.action          = ACT_OFFLINE_ONE;
        result.target_core     = c_idx;
        next_c                 = c_sat - 3'd1;
        streak_nxt.down_streak = RST_STREAK;
      end else begin
        streak_nxt.down_streak = streak.down_streak + 4'd1;
      end
      streak_nxt.up_streak = RST_STREAK;
    end else if (c_sat < NCORES) begin
      if (item.load_avg >= cfg.all_on_threshold) begin
        result.action          = ACT_ONLINE_ALL;
        next_c                 = NCORES;
        streak_nxt.down_streak = RST_STREAK;
      end else if (item.load_avg >= 16'(up_th_scaled)) begin
        if (streak.up_streak >= cfg.up_period) begin
          result.action        = ACT_ONLINE_ONE;
          result.target_core   = 2'(c_sat);
          next_c               = c_sat + 3'd1;
          streak_nxt.up_streak = RST_STREAK;
        end else begin
          streak_nxt.up_streak = streak.up_streak + 4'd1;
        end
        streak_nxt.down_streak = RST_STREAK;
      end
    end

    next_idx                = 2'(next_c - 3'd1);
    base_ivl                = cfg.interval_table[next_idx*8 +: 8];
    result.new_cores_online = next_c;
    result.next_interval_ms = 10'(base_ivl) * 10'(cfg.load_scale);
  end

endmodule

FILE: design/core_hotplug_load_governor.sv
// core hotplug load governor
// in channel: one transaction per load sample (load_avg, cores_online), in_valid/in_stall
// out channel: one transaction per sample with action, target_core, new_cores_online
//   and next_interval_ms, out_valid/out_stall
// cfg port: cfg_we writes cfg_wdata into register cfg_index at the clock edge, no read-back;
//   only write while no sample is in flight
// latency: a sample accepted at edge n shows on out at edge n+1 (valid after edge n+1),
//   i.e. two register stages: an input register then a result register
// throughput: one sample per cycle; the streak counters are read in the input stage and
//   updated as the sample moves into the result register, so the next sample sees them
// when the receiver stalls the result register holds; the input stage keeps working
//   while the result register is free or being drained, so in_stall only rises once
//   both stages are full
// reset (rst_n low, synchronous): both stages empty, registers back to their defaults,
//   both streak counters at one
module core_hotplug_load_governor #(
  parameter int NUM_CORES = chlg_pkg::NUM_CORES_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  chlg_pkg::in_item_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output chlg_pkg::out_item_t                 out_data,
  input  logic                                cfg_we,
  input  logic [chlg_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [chlg_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import chlg_pkg::*;

  `include "core_hotplug_load_governor_assert.svh"

  cfg_regs_t cfg_r, cfg_nxt;
  streak_t   streak_r, streak_nxt;
  logic      s1_valid_r, s1_valid_nxt;
  in_item_t  s1_item_r;
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_item_r;
  out_item_t result;
  logic      s1_adv;
  logic      in_fire;

  // input stage moves on when the result register is empty or draining
  assign s1_adv   = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !s1_adv;
  assign in_fire  = in_valid && !in_stall;

  assign s1_valid_nxt  = in_fire || (s1_valid_r && !s1_adv);
  assign out_valid_nxt = s1_adv || (out_valid_r && out_stall);

  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

  // decision logic on the registered sample
  chlg_decide #(
    .NUM_CORES (NUM_CORES)
  ) u_decide (
    .cfg        (cfg_r),
    .item       (s1_item_r),
    .streak     (streak_r),
    .result     (result),
    .streak_nxt (streak_nxt)
  );

  // register writes, unknown fields are masked by the field widths
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_ALL_ON_THRESHOLD: cfg_nxt.all_on_threshold = cfg_wdata[15:0];
        REG_UP_THRESHOLDS:    cfg_nxt.up_thresholds    = cfg_wdata[47:0];
        REG_DOWN_THRESHOLDS:  cfg_nxt.down_thresholds  = cfg_wdata[47:0];
        REG_INTERVAL_TABLE:   cfg_nxt.interval_table   = cfg_wdata[31:0];
        REG_DOWN_PERIODS:     cfg_nxt.down_periods     = cfg_wdata[15:0];
        REG_UP_PERIOD:        cfg_nxt.up_period        = cfg_wdata[3:0];
        REG_LOAD_SCALE:       cfg_nxt.load_scale       = cfg_wdata[1:0];
        REG_MIN_CORES:        cfg_nxt.min_cores        = cfg_wdata[2:0];
        default:              cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.all_on_threshold <= RST_ALL_ON_THRESHOLD;
      cfg_r.up_thresholds    <= RST_UP_THRESHOLDS;
      cfg_r.down_thresholds  <= RST_DOWN_THRESHOLDS;
      cfg_r.interval_table   <= RST_INTERVAL_TABLE;
      cfg_r.down_periods     <= RST_DOWN_PERIODS;
      cfg_r.up_period        <= RST_UP_PERIOD;
      cfg_r.load_scale       <= RST_LOAD_SCALE;
      cfg_r.min_cores        <= RST_MIN_CORES;
      streak_r.up_streak     <= RST_STREAK;
      streak_r.down_streak   <= RST_STREAK;
      s1_valid_r             <= 1'b0;
      out_valid_r            <= 1'b0;
    end else begin
      cfg_r       <= cfg_nxt;
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      // streaks follow each sample as it leaves the input stage
      if (s1_adv) begin
        streak_r <= streak_nxt;
      end
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_item_r <= in_data;
    end
    if (s1_adv) begin
      out_item_r <= result;
    end
  end

  // streak counters only ever hold 1..15
  `CHLG_ASSERT_IMP(a_streak_nonzero, 1'b1, (streak_r.up_streak != 4'd0) && (streak_r.down_streak != 4'd0))
  // offlining drops the count to the index of the core switched off
  `CHLG_ASSERT_IMP(a_offline_count, out_valid_r && (out_item_r.action == ACT_OFFLINE_ONE), out_item_r.new_cores_online == 3'(out_item_r.target_core))
  // onlining one core restarts the up streak
  `CHLG_ASSERT_NXT(a_online_resets_up, s1_adv && (result.action == ACT_ONLINE_ONE), streak_r.up_streak == RST_STREAK)
  // the input side is never held off while the result register is free
  `CHLG_ASSERT_IMP(a_no_stall_when_free, !out_valid_r, !in_stall)

endmodule
